// File: sv/slle_pkg.sv
`timescale 1ns / 1ps

package slle_pkg;

    localparam int NODES      = 8;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = $clog2(NODES);
    localparam int CNT_W      = $clog2(NODES + 1);
    localparam int POS_W      = 3;
    localparam int IN_W       = 32;
    localparam int IN_DATA_W  = ((POS_W + 2 * IN_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((IDX_W + 7) / 8) * 8;

    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [VALUE_BITS-1:0] t_val;

    localparam t_idx FREE_START = t_idx'(2);
    localparam t_idx HEAD_SLOT  = t_idx'(1);
    localparam t_idx NIL_SLOT   = t_idx'(0);

    typedef enum logic [1:0] {
        ACT_INSERT  = 2'd0,
        ACT_DELETE  = 2'd1,
        ACT_FIND    = 2'd2,
        ACT_REPLACE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_BAD_POS   = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_INS_FH,
        S_INS_WALK,
        S_INS_LINK,
        S_SRCH,
        S_CMP,
        S_DEL_FREE,
        S_RESP
    } t_state;

    typedef struct packed {
        logic en;
        t_idx addr;
        t_idx data;
    } t_next_wr;

    typedef struct packed {
        logic en;
        t_idx addr;
        t_val data;
    } t_val_wr;

    // Reset contents of the link store: free chain 2..NODES-1, all else 0.
    function automatic t_idx init_next(input t_idx slot);
        t_idx r;
        r = NIL_SLOT;
        if (slot >= FREE_START && slot < t_idx'(NODES - 1)) begin
            r = slot + t_idx'(1);
        end
        return r;
    endfunction

    function automatic t_val widen(input logic signed [IN_W-1:0] x);
        return t_val'(x);
    endfunction

endpackage

// File: sv/slle_store.sv
`timescale 1ns / 1ps

// Node store: link memory and value memory, one write and one read port each.
module slle_store (
    input  logic               i_clk,
    input  slle_pkg::t_idx     i_next_raddr,
    input  slle_pkg::t_next_wr i_next_wr,
    output slle_pkg::t_idx     o_next_rdata,
    input  slle_pkg::t_idx     i_val_raddr,
    input  slle_pkg::t_val_wr  i_val_wr,
    output slle_pkg::t_val     o_val_rdata
);

    slle_pkg::t_idx mem_next [slle_pkg::NODES];
    slle_pkg::t_val mem_val  [slle_pkg::NODES];

    always_ff @(posedge i_clk) begin
        if (i_next_wr.en) begin
            mem_next[i_next_wr.addr] <= i_next_wr.data;
        end
        o_next_rdata <= mem_next[i_next_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_val_wr.en) begin
            mem_val[i_val_wr.addr] <= i_val_wr.data;
        end
        o_val_rdata <= mem_val[i_val_raddr];
    end

endmodule

// File: sv/slle_seq.sv
`timescale 1ns / 1ps

// Sequencer: walks the chain through the store, commits edits, holds result.
module slle_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  slle_pkg::t_action    i_action,
    input  logic [2:0]           i_position,
    input  logic signed [31:0]   i_value,
    input  logic signed [31:0]   i_new_value,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output slle_pkg::t_status    o_status,
    output slle_pkg::t_idx       o_node_index,
    output slle_pkg::t_idx       o_next_raddr,
    output slle_pkg::t_next_wr   o_next_wr,
    input  slle_pkg::t_idx       i_next_rdata,
    output slle_pkg::t_idx       o_val_raddr,
    output slle_pkg::t_val_wr    o_val_wr,
    input  slle_pkg::t_val       i_val_rdata
);

    slle_pkg::t_state  r_state, n_state;
    slle_pkg::t_idx    r_init;
    slle_pkg::t_idx    r_fh;
    slle_pkg::t_idx    r_fnext;
    slle_pkg::t_idx    r_p;
    slle_pkg::t_idx    r_c;
    logic [2:0]        r_k;
    logic [2:0]        r_pos;
    logic [slle_pkg::CNT_W-1:0] r_steps;
    slle_pkg::t_action r_act;
    slle_pkg::t_val    r_val;
    slle_pkg::t_val    r_nval;
    slle_pkg::t_status r_res_status;
    slle_pkg::t_idx    r_res_idx;
    logic              r_out_valid;
    slle_pkg::t_status r_out_status;
    slle_pkg::t_idx    r_out_idx;

    logic accept;
    logic match;
    logic at_pos;
    logic walk_end;
    logic out_free;

    assign accept   = i_in_valid && o_in_ready;
    assign match    = (i_val_rdata == r_val);
    assign at_pos   = (r_k >= r_pos);
    assign walk_end = (i_next_rdata == slle_pkg::NIL_SLOT) ||
                      (r_steps >= slle_pkg::CNT_W'(slle_pkg::NODES - 1));
    assign out_free = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            slle_pkg::S_INIT: begin
                if (r_init == slle_pkg::t_idx'(slle_pkg::NODES - 1)) n_state = slle_pkg::S_IDLE;
            end
            slle_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_action != slle_pkg::ACT_INSERT) n_state = slle_pkg::S_SRCH;
                    else if (r_fh == slle_pkg::NIL_SLOT) n_state = slle_pkg::S_RESP;
                    else n_state = slle_pkg::S_INS_FH;
                end
            end
            slle_pkg::S_INS_FH:   n_state = slle_pkg::S_INS_WALK;
            slle_pkg::S_INS_WALK: begin
                if (at_pos) n_state = slle_pkg::S_INS_LINK;
                else if (i_next_rdata == slle_pkg::NIL_SLOT) n_state = slle_pkg::S_RESP;
            end
            slle_pkg::S_INS_LINK: n_state = slle_pkg::S_RESP;
            slle_pkg::S_SRCH: begin
                if (i_next_rdata == slle_pkg::NIL_SLOT) n_state = slle_pkg::S_RESP;
                else n_state = slle_pkg::S_CMP;
            end
            slle_pkg::S_CMP: begin
                if (match) begin
                    if (r_act == slle_pkg::ACT_DELETE) n_state = slle_pkg::S_DEL_FREE;
                    else n_state = slle_pkg::S_RESP;
                end else if (walk_end) begin
                    n_state = slle_pkg::S_RESP;
                end
            end
            slle_pkg::S_DEL_FREE: n_state = slle_pkg::S_RESP;
            slle_pkg::S_RESP: begin
                if (out_free) n_state = slle_pkg::S_IDLE;
            end
            default: n_state = slle_pkg::S_INIT;
        endcase
    end

    // memory port control
    always_comb begin
        o_in_ready   = 1'b0;
        o_next_raddr = slle_pkg::HEAD_SLOT;
        o_val_raddr  = slle_pkg::NIL_SLOT;
        o_next_wr    = '0;
        o_val_wr     = '0;
        unique case (r_state)
            slle_pkg::S_INIT: begin
                o_next_wr = '{en: 1'b1, addr: r_init, data: slle_pkg::init_next(r_init)};
            end
            slle_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_action == slle_pkg::ACT_INSERT) o_next_raddr = r_fh;
            end
            slle_pkg::S_INS_FH: ;
            slle_pkg::S_INS_WALK: begin
                if (at_pos) begin
                    o_next_wr = '{en: 1'b1, addr: r_fh, data: i_next_rdata};
                    o_val_wr  = '{en: 1'b1, addr: r_fh, data: r_val};
                end else begin
                    o_next_raddr = i_next_rdata;
                end
            end
            slle_pkg::S_INS_LINK: begin
                o_next_wr = '{en: 1'b1, addr: r_p, data: r_fh};
            end
            slle_pkg::S_SRCH: begin
                o_next_raddr = i_next_rdata;
                o_val_raddr  = i_next_rdata;
            end
            slle_pkg::S_CMP: begin
                if (match) begin
                    if (r_act == slle_pkg::ACT_DELETE) begin
                        o_next_wr = '{en: 1'b1, addr: r_p, data: i_next_rdata};
                    end else if (r_act == slle_pkg::ACT_REPLACE) begin
                        o_val_wr = '{en: 1'b1, addr: r_c, data: r_nval};
                    end
                end else begin
                    o_next_raddr = i_next_rdata;
                    o_val_raddr  = i_next_rdata;
                end
            end
            slle_pkg::S_DEL_FREE: begin
                o_next_wr = '{en: 1'b1, addr: r_c, data: r_fh};
            end
            slle_pkg::S_RESP: ;
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= slle_pkg::S_INIT;
            r_init      <= slle_pkg::NIL_SLOT;
            r_fh        <= slle_pkg::FREE_START;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == slle_pkg::S_INIT) r_init <= r_init + slle_pkg::t_idx'(1);
            if (r_state == slle_pkg::S_INS_LINK) r_fh <= r_fnext;
            if (r_state == slle_pkg::S_DEL_FREE) r_fh <= r_c;
            if (r_state == slle_pkg::S_RESP && out_free) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // walk and result registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            slle_pkg::S_IDLE: begin
                if (accept) begin
                    r_act   <= i_action;
                    r_pos   <= i_position;
                    r_val   <= slle_pkg::widen(i_value);
                    r_nval  <= slle_pkg::widen(i_new_value);
                    r_p     <= slle_pkg::HEAD_SLOT;
                    r_k     <= 3'd1;
                    r_steps <= '0;
                    r_res_status <= slle_pkg::ST_FULL;
                    r_res_idx    <= slle_pkg::NIL_SLOT;
                end
            end
            slle_pkg::S_INS_FH: r_fnext <= i_next_rdata;
            slle_pkg::S_INS_WALK: begin
                if (!at_pos) begin
                    r_p <= i_next_rdata;
                    r_k <= r_k + 3'd1;
                    if (i_next_rdata == slle_pkg::NIL_SLOT) begin
                        r_res_status <= slle_pkg::ST_BAD_POS;
                        r_res_idx    <= slle_pkg::NIL_SLOT;
                    end
                end
            end
            slle_pkg::S_INS_LINK: begin
                r_res_status <= slle_pkg::ST_OK;
                r_res_idx    <= r_fh;
            end
            slle_pkg::S_SRCH: begin
                r_c          <= i_next_rdata;
                r_res_status <= slle_pkg::ST_NOT_FOUND;
                r_res_idx    <= slle_pkg::NIL_SLOT;
            end
            slle_pkg::S_CMP: begin
                if (match) begin
                    r_res_status <= slle_pkg::ST_OK;
                    r_res_idx    <= r_c;
                end else begin
                    r_p     <= r_c;
                    r_c     <= i_next_rdata;
                    r_steps <= r_steps + slle_pkg::CNT_W'(1);
                end
            end
            slle_pkg::S_RESP: begin
                if (out_free) begin
                    r_out_status <= r_res_status;
                    r_out_idx    <= r_res_idx;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_node_index = r_out_idx;

endmodule

// File: sv/static_linked_list_engine.sv
`timescale 1ns / 1ps

// Static linked list engine.
// A singly linked list of NODES slots lives in two synchronous memories
// (link and value). Slot 1 is the list head sentinel, slot 0 is "none".
// Input channel (s_axis): one transfer is one command; tuser carries the
// action (insert, delete, find, replace), tdata the position and operands.
// Output channel (m_axis): exactly one transfer per command, carrying the
// status in tuser and the slot touched in tdata (0 unless status is ok).
// Commands are worked one at a time; each is a walk over the link memory,
// one element per cycle since the next link read address comes straight
// from the previous read data. An insert walks to its position (position 0
// counts as 1), or to the list end for a bad position; find, replace and
// delete walk to the first match or the list end, and delete then adds a
// step that returns the slot to the free chain. A full store goes straight
// to the result.
// Reset: after i_rst_n rises the link memory is swept once, slot by slot,
// to build the free chain, while s_axis_tready stays low.
// Output stall: a finished result waits in the output register; the block
// takes and works the next command meanwhile and stalls only when that
// second result is ready before the first was taken.
module static_linked_list_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] position, [34:3] value, [66:35] new_value, rest zero
    input  logic [slle_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // [1:0] action
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] node_index, rest zero
    output logic [slle_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // [1:0] status
    output logic [1:0]  m_axis_tuser
);

    slle_pkg::t_idx     next_raddr, next_rdata, val_raddr, node_index;
    slle_pkg::t_next_wr next_wr;
    slle_pkg::t_val_wr  val_wr;
    slle_pkg::t_val     val_rdata;
    slle_pkg::t_status  status;

    slle_store u_store (
        .i_clk        (i_clk),
        .i_next_raddr (next_raddr),
        .i_next_wr    (next_wr),
        .o_next_rdata (next_rdata),
        .i_val_raddr  (val_raddr),
        .i_val_wr     (val_wr),
        .o_val_rdata  (val_rdata)
    );

    slle_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_action     (slle_pkg::t_action'(s_axis_tuser)),
        .i_position   (s_axis_tdata[2:0]),
        .i_value      (s_axis_tdata[34:3]),
        .i_new_value  (s_axis_tdata[66:35]),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_status     (status),
        .o_node_index (node_index),
        .o_next_raddr (next_raddr),
        .o_next_wr    (next_wr),
        .i_next_rdata (next_rdata),
        .o_val_raddr  (val_raddr),
        .o_val_wr     (val_wr),
        .i_val_rdata  (val_rdata)
    );

    assign m_axis_tuser = status;
    assign m_axis_tdata = slle_pkg::OUT_DATA_W'(node_index);

endmodule

// File: sv/slle_checker.sv
`timescale 1ns / 1ps

module slle_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [1:0] m_axis_tuser
);

    // one command in flight: no accept on the cycle right after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted back to back");

    a_fail_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != slle_pkg::ST_OK) |-> (m_axis_tdata == 8'd0))
        else $error("failed command reports a slot");

    a_ok_real_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == slle_pkg::ST_OK) |->
        (m_axis_tdata[2:0] != 3'd0) && (m_axis_tdata[2:0] != 3'd1) &&
        (m_axis_tdata[7:3] == 5'd0))
        else $error("ok result names the free marker or the sentinel");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind static_linked_list_engine slle_checker u_slle_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: tb/sv/tb_static_linked_list_engine.sv
`timescale 1ns / 1ps

module tb_static_linked_list_engine;

    localparam int N_RANDOM  = 580;
    localparam int LONG_HOLD = 80;   // receiver hold-off, long enough to back up the input
    localparam int DRAIN     = 24;   // cycles to watch for stray results at the end

    // One directed row: command plus, where obvious, the result it must give.
    typedef struct packed {
        slle_pkg::t_action          act;
        logic [slle_pkg::POS_W-1:0] pos;
        slle_pkg::t_val             val;
        slle_pkg::t_val             nval;
        logic                       typed;
        slle_pkg::t_status          st;
        slle_pkg::t_idx             idx;
    } t_dir_row;

    typedef struct {
        slle_pkg::t_status st;
        slle_pkg::t_idx    idx;
    } t_list_result;

    localparam int DIR_N = 25;
    localparam t_dir_row DIR_ROWS [DIR_N] = '{
        // empty list: nothing matches, not even the sentinel's -1
        '{slle_pkg::ACT_FIND,    3'd1, 32'hFFFF_FFFF, 32'h0, 1'b1, slle_pkg::ST_NOT_FOUND, 3'd0},
        '{slle_pkg::ACT_DELETE,  3'd1, 32'hFFFF_FFFF, 32'h0, 1'b1, slle_pkg::ST_NOT_FOUND, 3'd0},
        '{slle_pkg::ACT_REPLACE, 3'd1, 32'h0, 32'h1, 1'b1, slle_pkg::ST_NOT_FOUND, 3'd0},
        '{slle_pkg::ACT_INSERT,  3'd2, 32'h5, 32'h0, 1'b1, slle_pkg::ST_BAD_POS, 3'd0},
        // position zero acts as the front
        '{slle_pkg::ACT_INSERT,  3'd0, 32'h8000_0000, 32'h0, 1'b1, slle_pkg::ST_OK, 3'd2},
        '{slle_pkg::ACT_INSERT,  3'd7, 32'h5, 32'h0, 1'b1, slle_pkg::ST_BAD_POS, 3'd0},
        '{slle_pkg::ACT_INSERT,  3'd2, 32'h7FFF_FFFF, 32'h0, 1'b1, slle_pkg::ST_OK, 3'd3},
        '{slle_pkg::ACT_INSERT,  3'd1, 32'hFFFF_FFFF, 32'h0, 1'b1, slle_pkg::ST_OK, 3'd4},
        '{slle_pkg::ACT_INSERT,  3'd3, 32'h0, 32'h0, 1'b1, slle_pkg::ST_OK, 3'd5},
        '{slle_pkg::ACT_INSERT,  3'd5, 32'h0, 32'h0, 1'b1, slle_pkg::ST_OK, 3'd6},
        '{slle_pkg::ACT_INSERT,  3'd6, 32'h5555_5555, 32'h0, 1'b1, slle_pkg::ST_OK, 3'd7},
        // store full, reported ahead of a bad position
        '{slle_pkg::ACT_INSERT,  3'd1, 32'h1, 32'h0, 1'b1, slle_pkg::ST_FULL, 3'd0},
        '{slle_pkg::ACT_INSERT,  3'd7, 32'h1, 32'h0, 1'b1, slle_pkg::ST_FULL, 3'd0},
        // the rest follow the list state
        '{slle_pkg::ACT_FIND,    3'd4, 32'hFFFF_FFFF, 32'h0, 1'b0, slle_pkg::ST_OK, 3'd0},
        '{slle_pkg::ACT_FIND,    3'd5, 32'h0, 32'h0, 1'b0, slle_pkg::ST_OK, 3'd0},
        '{slle_pkg::ACT_REPLACE, 3'd6, 32'h0, 32'hAAAA_AAAA, 1'b0, slle_pkg::ST_OK, 3'd0},
        '{slle_pkg::ACT_DELETE,  3'd7, 32'h0, 32'h0, 1'b0, slle_pkg::ST_OK, 3'd0},
        '{slle_pkg::ACT_DELETE,  3'd1, 32'h8000_0000, 32'h0, 1'b0, slle_pkg::ST_OK, 3'd0},
        '{slle_pkg::ACT_INSERT,  3'd1, 32'h1234_5678, 32'h0, 1'b0, slle_pkg::ST_OK, 3'd0},
        '{slle_pkg::ACT_REPLACE, 3'd2, 32'h5555_5555, 32'hFFFF_FFFE, 1'b0, slle_pkg::ST_OK, 3'd0},
        '{slle_pkg::ACT_DELETE,  3'd3, 32'h7FFF_FFFF, 32'h0, 1'b0, slle_pkg::ST_OK, 3'd0},
        '{slle_pkg::ACT_FIND,    3'd1, 32'hAAAA_AAAA, 32'h0, 1'b0, slle_pkg::ST_OK, 3'd0},
        '{slle_pkg::ACT_DELETE,  3'd1, 32'hFFFF_FFFF, 32'h0, 1'b0, slle_pkg::ST_OK, 3'd0},
        '{slle_pkg::ACT_INSERT,  3'd4, 32'h1, 32'h0, 1'b0, slle_pkg::ST_OK, 3'd0},
        '{slle_pkg::ACT_INSERT,  3'd6, 32'h2, 32'h0, 1'b0, slle_pkg::ST_OK, 3'd0}
    };

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [slle_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]                      s_axis_tuser = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [slle_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]                      m_axis_tuser;

    // Mirror of the node store and the two chain heads.
    slle_pkg::t_val lst_val  [slle_pkg::NODES];
    slle_pkg::t_idx lst_next [slle_pkg::NODES];
    slle_pkg::t_idx free_top;
    slle_pkg::t_idx head_slot;
    slle_pkg::t_val listed_vals [$];

    t_list_result pending_results [$];
    int           mismatch_cnt = 0;
    bit           idle_on = 1'b1;
    bit           hold_req = 1'b0;

    slle_pkg::t_val value_pool [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                                       32'hFFFF_FFFF};

    static_linked_list_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #(2_000_000);
        $display("FAILED: results differ");
        $finish;
    end

    function automatic void list_reset();
        for (int i = 0; i < slle_pkg::NODES; i++) begin
            lst_val[i]  = '0;
            lst_next[i] = (i >= 2 && i < slle_pkg::NODES - 1) ?
                          slle_pkg::t_idx'(i + 1) : slle_pkg::NIL_SLOT;
        end
        lst_val[slle_pkg::HEAD_SLOT] = '1;
        free_top  = slle_pkg::FREE_START;
        head_slot = slle_pkg::HEAD_SLOT;
    endfunction

    // Apply one command to the mirror and return the result it must produce.
    function automatic void list_apply(input slle_pkg::t_action act,
                                       input logic [slle_pkg::POS_W-1:0] pos,
                                       input slle_pkg::t_val v, input slle_pkg::t_val nv,
                                       output slle_pkg::t_status st,
                                       output slle_pkg::t_idx idx);
        slle_pkg::t_idx p;
        slle_pkg::t_idx nx;
        slle_pkg::t_idx hit;
        slle_pkg::t_idx prev;
        slle_pkg::t_idx fh;
        bit             reach;
        st   = slle_pkg::ST_OK;
        idx  = slle_pkg::NIL_SLOT;
        hit  = slle_pkg::NIL_SLOT;
        prev = slle_pkg::NIL_SLOT;
        if (act == slle_pkg::ACT_INSERT) begin
            fh = free_top;
            if (fh == slle_pkg::NIL_SLOT) begin
                st = slle_pkg::ST_FULL;
            end else begin
                p     = head_slot;
                reach = 1'b1;
                for (int i = 1; i < int'(pos) && reach; i++) begin
                    nx = lst_next[p];
                    if (nx == slle_pkg::NIL_SLOT) reach = 1'b0;
                    else p = nx;
                end
                if (!reach) begin
                    st = slle_pkg::ST_BAD_POS;
                end else begin
                    free_top     = lst_next[fh];
                    lst_val[fh]  = v;
                    lst_next[fh] = lst_next[p];
                    lst_next[p]  = fh;
                    idx          = fh;
                end
            end
        end else begin
            // first match from the front; the sentinel itself is never compared
            p = head_slot;
            for (int i = 0; i < slle_pkg::NODES && hit == slle_pkg::NIL_SLOT; i++) begin
                nx = lst_next[p];
                if (nx == slle_pkg::NIL_SLOT) break;
                if (lst_val[nx] == v) begin
                    hit  = nx;
                    prev = p;
                end
                p = nx;
            end
            if (hit == slle_pkg::NIL_SLOT) begin
                st = slle_pkg::ST_NOT_FOUND;
            end else begin
                idx = hit;
                if (act == slle_pkg::ACT_DELETE) begin
                    lst_next[prev] = lst_next[hit];
                    lst_next[hit]  = free_top;
                    free_top       = hit;
                end else if (act == slle_pkg::ACT_REPLACE) begin
                    lst_val[hit] = nv;
                end
            end
        end
    endfunction

    // Collects the current list values and returns the list length.
    function automatic int walk_list();
        slle_pkg::t_idx p;
        int             n;
        listed_vals.delete();
        p = head_slot;
        n = 0;
        for (int i = 0; i < slle_pkg::NODES; i++) begin
            p = lst_next[p];
            if (p == slle_pkg::NIL_SLOT) break;
            listed_vals.push_back(lst_val[p]);
            n++;
        end
        return n;
    endfunction

    // Offer one command, hold it until the transfer, then log what must come back.
    task automatic send_cmd(input slle_pkg::t_action act,
                            input logic [slle_pkg::POS_W-1:0] pos,
                            input slle_pkg::t_val v, input slle_pkg::t_val nv,
                            input bit typed, input slle_pkg::t_status tst,
                            input slle_pkg::t_idx tidx);
        logic [slle_pkg::IN_DATA_W-1:0] word;
        t_list_result                   res;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        word = '0;
        word[slle_pkg::POS_W-1:0] = pos;
        word[slle_pkg::POS_W+slle_pkg::IN_W-1:slle_pkg::POS_W] = v[slle_pkg::IN_W-1:0];
        word[slle_pkg::POS_W+2*slle_pkg::IN_W-1:slle_pkg::POS_W+slle_pkg::IN_W] =
            nv[slle_pkg::IN_W-1:0];
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= act;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        list_apply(act, pos, v, nv, res.st, res.idx);
        if (typed) begin
            res.st  = tst;
            res.idx = tidx;
        end
        pending_results.push_back(res);
    endtask

    // Receiver: random stalls, one long hold-off on request, none near the end.
    initial begin
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Result checker: every transfer out is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d node_index %0d",
                       m_axis_tuser, m_axis_tdata[slle_pkg::IDX_W-1:0]);
                mismatch_cnt++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser != want.st) begin
                    $error("status mismatch: expected %0d, actual %0d", want.st, m_axis_tuser);
                    mismatch_cnt++;
                end
                if (m_axis_tdata[slle_pkg::IDX_W-1:0] != want.idx) begin
                    $error("node_index mismatch: expected %0d, actual %0d",
                           want.idx, m_axis_tdata[slle_pkg::IDX_W-1:0]);
                    mismatch_cnt++;
                end
            end
        end
    end

    // Sender: directed rows, a full drain, random traffic, then a final drain.
    initial begin
        int                         len;
        int                         r;
        slle_pkg::t_action          act;
        logic [slle_pkg::POS_W-1:0] pos;
        slle_pkg::t_val             v;
        slle_pkg::t_val             nv;
        list_reset();
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);

        for (int k = 0; k < DIR_N; k++) begin
            send_cmd(DIR_ROWS[k].act, DIR_ROWS[k].pos, DIR_ROWS[k].val, DIR_ROWS[k].nval,
                     DIR_ROWS[k].typed, DIR_ROWS[k].st, DIR_ROWS[k].idx);
        end

        // pause until every outstanding result is back
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);

        for (int k = 0; k < N_RANDOM; k++) begin
            if (k == 120) hold_req = 1'b1;
            if (k == N_RANDOM - 60) idle_on = 1'b0;
            len = walk_list();
            r   = $urandom_range(0, 99);
            if (r < 36) act = slle_pkg::ACT_INSERT;
            else if (r < 66) act = slle_pkg::ACT_DELETE;
            else if (r < 82) act = slle_pkg::ACT_FIND;
            else act = slle_pkg::ACT_REPLACE;
            // mostly hit values on the list, with extremes and noise mixed in
            r = $urandom_range(0, 9);
            if (r < 6 && listed_vals.size() > 0)
                v = listed_vals[$urandom_range(0, listed_vals.size() - 1)];
            else if (r < 8)
                v = value_pool[$urandom_range(0, 3)];
            else
                v = $urandom();
            nv = ($urandom_range(0, 3) == 0) ? value_pool[$urandom_range(0, 3)] : $urandom();
            if ($urandom_range(0, 7) == 0)
                pos = slle_pkg::POS_W'($urandom_range(0, 7));
            else
                pos = slle_pkg::POS_W'($urandom_range(1, len + 1));
            send_cmd(act, pos, v, nv, 1'b0, slle_pkg::ST_OK, slle_pkg::NIL_SLOT);
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        if (mismatch_cnt == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
